// File: hw/rtl/idtf_pkg.sv
package idtf_pkg;

    localparam int DEF_SLOTS          = 8;
    localparam int DEF_MAX_SLOT_BYTES = 3072;
    localparam int DEF_PAGE_POINTERS  = 7;

    localparam int ADDR_W     = 32;
    localparam int LEN_W      = 15;
    localparam int SLOT_W     = 3;
    localparam int SLEN_W     = 12;
    localparam int PIDX_W     = 3;
    localparam int OFS_W      = 12;
    localparam int BASE_W     = ADDR_W - OFS_W;
    localparam int PCNT_W     = 4;
    localparam int MPS_W      = 11;
    localparam int PPM_W      = 2;
    localparam int LOW_W      = 12;
    localparam int CAP_W      = MPS_W + PPM_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PACKET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE0_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE1_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE2_LOW  = 3'd4;

    localparam logic [MPS_W-1:0] MPS_RESET = 11'd1024;
    localparam logic [PPM_W-1:0] PPM_RESET = 2'd1;

    localparam logic [PIDX_W-1:0] PIDX_MAX = 3'd7;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              active;
        logic [SLEN_W-1:0] len;
        logic              ioc;
        logic [PIDX_W-1:0] idx;
        logic              page_write;
        logic              page_overflow;
        logic [BASE_W-1:0] base;
        logic [OFS_W-1:0]  offset;
        logic              last;
    } t_slot;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              active;
        logic [SLEN_W-1:0] len;
        logic              ioc;
        logic [PIDX_W-1:0] idx;
        logic              page_write;
        logic              page_overflow;
        logic [ADDR_W-1:0] page_word;
        logic [OFS_W-1:0]  offset;
        logic              last;
    } t_page;

endpackage

// File: hw/rtl/idtf_seq.sv
module idtf_seq
    import idtf_pkg::*;
#(
    parameter int SLOTS          = DEF_SLOTS,
    parameter int MAX_SLOT_BYTES = DEF_MAX_SLOT_BYTES,
    parameter int PAGE_POINTERS  = DEF_PAGE_POINTERS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [ADDR_W-1:0] i_buffer_address,
    input  logic [LEN_W-1:0]  i_buffer_length,
    input  logic [MPS_W-1:0]  i_max_packet_size,
    input  logic [PPM_W-1:0]  i_packets_per_microframe,
    output logic              o_slot_valid,
    input  logic              i_slot_ready,
    output t_slot             o_slot
);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
    localparam logic [CAP_W-1:0]  CAP_MAX   = CAP_W'(MAX_SLOT_BYTES);
    localparam logic [PCNT_W-1:0] PP_LIMIT  = PCNT_W'(PAGE_POINTERS);
    localparam logic [PCNT_W-1:0] PCNT_MAX  = PCNT_W'(8);

    logic              r_busy;
    logic [ADDR_W-1:0] r_addr;
    logic [LEN_W-1:0]  r_left;
    logic              r_have_page;
    logic [BASE_W-1:0] r_cur_page;
    logic [PCNT_W-1:0] r_page_count;
    logic [SLOT_W-1:0] r_slot_num;
    logic [SLEN_W-1:0] r_cap;
    logic              r_slot_valid;
    t_slot             r_slot;

    logic [CAP_W-1:0]  n_prod;
    logic              s1_ready;
    logic              step;
    logic              active;
    logic [BASE_W-1:0] base;
    logic              new_page;
    logic [PIDX_W-1:0] idx_new;
    logic [PIDX_W-1:0] idx_old;
    logic              ovf;
    logic [SLEN_W-1:0] len;
    logic [LEN_W-1:0]  left_next;
    t_slot             n_slot;

    assign n_prod = CAP_W'(i_max_packet_size) * CAP_W'(i_packets_per_microframe);

    always_ff @(posedge i_clk) begin
        r_cap <= (n_prod > CAP_MAX) ? SLEN_W'(CAP_MAX) : SLEN_W'(n_prod);
    end

    assign s1_ready   = !r_slot_valid || i_slot_ready;
    assign step       = r_busy && s1_ready;
    assign o_in_ready = !r_busy || (s1_ready && (r_slot_num == LAST_SLOT));

    assign active    = (r_left != '0);
    assign base      = r_addr[ADDR_W-1:OFS_W];
    assign new_page  = !r_have_page || (base != r_cur_page);
    assign idx_new   = r_page_count[PCNT_W-1] ? PIDX_MAX : r_page_count[PIDX_W-1:0];
    assign idx_old   = (r_page_count == '0) ? '0 : PIDX_W'(r_page_count - PCNT_W'(1));
    assign ovf       = ({1'b0, idx_new} >= PP_LIMIT);
    assign len       = (r_left > LEN_W'(r_cap)) ? r_cap : SLEN_W'(r_left);
    assign left_next = r_left - LEN_W'(len);

    always_comb begin
        n_slot               = '0;
        n_slot.slot          = r_slot_num;
        n_slot.last          = (r_slot_num == LAST_SLOT);
        n_slot.active        = active;
        n_slot.len           = len;
        n_slot.idx           = new_page ? idx_new : idx_old;
        n_slot.page_write    = active && new_page && !ovf;
        n_slot.page_overflow = active && new_page && ovf;
        n_slot.base          = base;
        n_slot.offset        = r_addr[OFS_W-1:0];
        n_slot.ioc           = active && ((left_next == '0) || (r_slot_num == LAST_SLOT));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_slot_valid <= 1'b0;
            r_slot_num   <= '0;
            r_have_page  <= 1'b0;
            r_page_count <= '0;
        end else begin
            if (s1_ready) begin
                r_slot_valid <= step;
            end
            if (i_in_valid && o_in_ready) begin
                r_busy       <= 1'b1;
                r_slot_num   <= '0;
                r_have_page  <= 1'b0;
                r_page_count <= '0;
            end else if (step) begin
                r_slot_num <= r_slot_num + SLOT_W'(1);
                if (r_slot_num == LAST_SLOT) begin
                    r_busy <= 1'b0;
                end
                if (active && new_page) begin
                    r_have_page <= 1'b1;
                    if (r_page_count < PCNT_MAX) begin
                        r_page_count <= r_page_count + PCNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_addr <= i_buffer_address;
            r_left <= i_buffer_length;
        end else if (step && active) begin
            r_addr <= r_addr + ADDR_W'(len);
            r_left <= left_next;
        end
        if (step && active && new_page) begin
            r_cur_page <= base;
        end
        if (step) begin
            r_slot <= n_slot;
        end
    end

    assign o_slot_valid = r_slot_valid;
    assign o_slot       = r_slot;

endmodule

// File: hw/rtl/idtf_pack.sv
module idtf_pack
    import idtf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_slot_valid,
    output logic              o_slot_ready,
    input  t_slot             i_slot,
    input  logic [LOW_W-1:0]  i_page0_low_bits,
    input  logic [LOW_W-1:0]  i_page1_low_bits,
    input  logic [LOW_W-1:0]  i_page2_low_bits,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [SLOT_W-1:0] o_slot_index,
    output logic [31:0]       o_transaction_word,
    output logic [SLEN_W-1:0] o_slot_length,
    output logic              o_page_write,
    output logic [PIDX_W-1:0] o_page_index,
    output logic [ADDR_W-1:0] o_page_word,
    output logic              o_page_overflow,
    output logic              o_last
);

    logic              r_s2_valid;
    t_page             r_s2;
    logic              r_out_valid;
    logic [SLOT_W-1:0] r_slot_index;
    logic [31:0]       r_word;
    logic [SLEN_W-1:0] r_len;
    logic              r_pw;
    logic [PIDX_W-1:0] r_pidx;
    logic [ADDR_W-1:0] r_pword;
    logic              r_ovf;
    logic              r_last;

    logic              s3_ready;
    logic              s2_ready;
    logic [LOW_W-1:0]  low;
    t_page             n_s2;
    logic [31:0]       n_word;

    assign s3_ready     = !r_out_valid || i_out_ready;
    assign s2_ready     = !r_s2_valid || s3_ready;
    assign o_slot_ready = s2_ready;

    always_comb begin
        unique case (i_slot.idx)
            PIDX_W'(0): low = i_page0_low_bits;
            PIDX_W'(1): low = i_page1_low_bits;
            PIDX_W'(2): low = i_page2_low_bits;
            default:    low = '0;
        endcase
    end

    always_comb begin
        n_s2               = '0;
        n_s2.slot          = i_slot.slot;
        n_s2.active        = i_slot.active;
        n_s2.len           = i_slot.len;
        n_s2.ioc           = i_slot.ioc;
        n_s2.idx           = i_slot.idx;
        n_s2.page_write    = i_slot.page_write;
        n_s2.page_overflow = i_slot.page_overflow;
        n_s2.page_word     = i_slot.page_write ? {i_slot.base, OFS_W'(low)} : '0;
        n_s2.offset        = i_slot.offset;
        n_s2.last          = i_slot.last;
    end

    assign n_word = r_s2.active ? {1'b1, 3'b000, r_s2.len, r_s2.ioc, r_s2.idx, r_s2.offset}
                                : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s2_ready) begin
                r_s2_valid <= i_slot_valid;
            end
            if (s3_ready) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && i_slot_valid) begin
            r_s2 <= n_s2;
        end
        if (s3_ready && r_s2_valid) begin
            r_slot_index <= r_s2.slot;
            r_word       <= n_word;
            r_len        <= r_s2.len;
            r_pw         <= r_s2.page_write;
            r_pidx       <= r_s2.page_write ? r_s2.idx : '0;
            r_pword      <= r_s2.page_word;
            r_ovf        <= r_s2.page_overflow;
            r_last       <= r_s2.last;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_slot_index       = r_slot_index;
    assign o_transaction_word = r_word;
    assign o_slot_length      = r_len;
    assign o_page_write       = r_pw;
    assign o_page_index       = r_pidx;
    assign o_page_word        = r_pword;
    assign o_page_overflow    = r_ovf;
    assign o_last             = r_last;

endmodule

// File: hw/rtl/iso_descriptor_transaction_fill_core.sv
// Isochronous descriptor transaction fill. Each request (buffer address, byte
// length) yields SLOTS slot results in slot order, one per cycle unless the
// output stalls, the last one flagged by o_last; a request occupies the block
// until the slot sequencer, which produces one slot per cycle unless stalled,
// has issued all SLOTS (8 by default). The next request is taken in the cycle
// the current one's final slot leaves the sequencer, so requests stream
// without gaps. Each slot result is registered by the sequencer, page pointer
// and word packing stages in turn. Configuration writes must only be issued
// while no request is in flight; o_cfg_ready is always high.
module iso_descriptor_transaction_fill_core
    import idtf_pkg::*;
#(
    parameter int SLOTS          = DEF_SLOTS,
    parameter int MAX_SLOT_BYTES = DEF_MAX_SLOT_BYTES,
    parameter int PAGE_POINTERS  = DEF_PAGE_POINTERS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [ADDR_W-1:0]     i_buffer_address,
    input  logic [LEN_W-1:0]      i_buffer_length,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [SLOT_W-1:0]     o_slot_index,
    output logic [31:0]           o_transaction_word,
    output logic [SLEN_W-1:0]     o_slot_length,
    output logic                  o_page_write,
    output logic [PIDX_W-1:0]     o_page_index,
    output logic [ADDR_W-1:0]     o_page_word,
    output logic                  o_page_overflow,
    output logic                  o_last
);

    logic [MPS_W-1:0] r_max_packet_size;
    logic [PPM_W-1:0] r_packets_per_microframe;
    logic [LOW_W-1:0] r_page0_low_bits;
    logic [LOW_W-1:0] r_page1_low_bits;
    logic [LOW_W-1:0] r_page2_low_bits;

    logic  slot_valid;
    logic  slot_ready;
    t_slot slot;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_packet_size        <= MPS_RESET;
            r_packets_per_microframe <= PPM_RESET;
            r_page0_low_bits         <= '0;
            r_page1_low_bits         <= '0;
            r_page2_low_bits         <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_PACKET: r_max_packet_size        <= i_cfg_data[MPS_W-1:0];
                CFG_MULT:       r_packets_per_microframe <= i_cfg_data[PPM_W-1:0];
                CFG_PAGE0_LOW:  r_page0_low_bits         <= i_cfg_data[LOW_W-1:0];
                CFG_PAGE1_LOW:  r_page1_low_bits         <= i_cfg_data[LOW_W-1:0];
                CFG_PAGE2_LOW:  r_page2_low_bits         <= i_cfg_data[LOW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    idtf_seq #(
        .SLOTS          (SLOTS),
        .MAX_SLOT_BYTES (MAX_SLOT_BYTES),
        .PAGE_POINTERS  (PAGE_POINTERS)
    ) u_seq (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_in_valid               (i_in_valid),
        .o_in_ready               (o_in_ready),
        .i_buffer_address         (i_buffer_address),
        .i_buffer_length          (i_buffer_length),
        .i_max_packet_size        (r_max_packet_size),
        .i_packets_per_microframe (r_packets_per_microframe),
        .o_slot_valid             (slot_valid),
        .i_slot_ready             (slot_ready),
        .o_slot                   (slot)
    );

    idtf_pack u_pack (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_slot_valid       (slot_valid),
        .o_slot_ready       (slot_ready),
        .i_slot             (slot),
        .i_page0_low_bits   (r_page0_low_bits),
        .i_page1_low_bits   (r_page1_low_bits),
        .i_page2_low_bits   (r_page2_low_bits),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_slot_index       (o_slot_index),
        .o_transaction_word (o_transaction_word),
        .o_slot_length      (o_slot_length),
        .o_page_write       (o_page_write),
        .o_page_index       (o_page_index),
        .o_page_word        (o_page_word),
        .o_page_overflow    (o_page_overflow),
        .o_last             (o_last)
    );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb
    import idtf_pkg::*;
();

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          SETTLE       = 16;
    localparam int          IDLE_PCT     = 35;
    localparam int          RAND_PHASES  = 8;
    localparam int          PHASE_ITEMS  = 50;
    localparam logic [31:0] PAGE_MASK    = 32'hFFFF_F000;
    localparam logic [2:0]  CFG_FIRST_UNUSED = CFG_PAGE2_LOW + 3'd1;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [31:0]       word;
        logic [SLEN_W-1:0] len;
        logic              pw;
        logic [PIDX_W-1:0] pidx;
        logic [ADDR_W-1:0] pword;
        logic              ovf;
        logic              is_last;
    } t_slot_rec;

    class slot_scoreboard;
        logic [MPS_W-1:0] max_packet;
        logic [PPM_W-1:0] mult;
        logic [LOW_W-1:0] low_bits [3];
        t_slot_rec        pending [$];
        int               errors;
        int               checked;
        int               requests;
        int               page_writes;
        int               active_slots;

        function new();
            max_packet = MPS_RESET;
            mult       = PPM_RESET;
            foreach (low_bits[k]) low_bits[k] = '0;
            errors = 0;
            checked = 0;
            requests = 0;
            page_writes = 0;
            active_slots = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MAX_PACKET: max_packet  = data[MPS_W-1:0];
                CFG_MULT:       mult        = data[PPM_W-1:0];
                CFG_PAGE0_LOW:  low_bits[0] = data[LOW_W-1:0];
                CFG_PAGE1_LOW:  low_bits[1] = data[LOW_W-1:0];
                CFG_PAGE2_LOW:  low_bits[2] = data[LOW_W-1:0];
                default: ;
            endcase
        endfunction

        // spread one request over the slots and queue the slot results
        function void note_request(logic [ADDR_W-1:0] addr_in, logic [LEN_W-1:0] len_in);
            logic [31:0] addr;
            logic [31:0] base;
            logic [31:0] cur_base;
            int          left;
            int          cap;
            int          pcount;
            int          idx;
            int          take;
            bit          have;
            t_slot_rec   r;
            requests++;
            addr     = addr_in;
            left     = len_in;
            cap      = max_packet * mult;
            if (cap > DEF_MAX_SLOT_BYTES) cap = DEF_MAX_SLOT_BYTES;
            have     = 1'b0;
            cur_base = '0;
            pcount   = 0;
            for (int s = 0; s < DEF_SLOTS; s++) begin
                r         = '0;
                r.slot    = s[SLOT_W-1:0];
                r.is_last = (s == DEF_SLOTS - 1);
                if (left != 0) begin
                    base = addr & PAGE_MASK;
                    idx  = (pcount == 0) ? 0 : pcount - 1;
                    if (!have || base != cur_base) begin
                        idx = pcount;
                        if (pcount < 8) pcount++;
                        if (idx > 7) idx = 7;
                        if (idx >= DEF_PAGE_POINTERS) begin
                            r.ovf = 1'b1;
                        end else begin
                            r.pw    = 1'b1;
                            r.pidx  = idx[PIDX_W-1:0];
                            r.pword = base | ((idx < 3) ? {20'd0, low_bits[idx]} : 32'd0);
                        end
                        have     = 1'b1;
                        cur_base = base;
                    end
                    take = (left > cap) ? cap : left;
                    left -= take;
                    r.len  = take[SLEN_W-1:0];
                    r.word = {1'b1, 3'b000, take[11:0],
                              (left == 0 || s == DEF_SLOTS - 1), idx[2:0], addr[11:0]};
                    addr   = addr + take;
                end
                pending.push_back(r);
            end
        endfunction

        function string fmt(t_slot_rec r);
            return $sformatf("slot %0d word %h len %0d pw %b pidx %0d pword %h ovf %b last %b",
                             r.slot, r.word, r.len, r.pw, r.pidx, r.pword, r.ovf, r.is_last);
        endfunction

        function void check_result(t_slot_rec got);
            t_slot_rec want;
            checked++;
            if (got.pw) page_writes++;
            if (got.word[31]) active_slots++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected slot result: %s", fmt(got));
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("slot mismatch in request %0d", requests - pending.size() / DEF_SLOTS);
                    $display("  expected: %s", fmt(want));
                    $display("  actual:   %s", fmt(got));
                end
            end
        endfunction
    endclass

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_cfg_valid      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;
    logic                  i_in_valid       = 1'b0;
    logic [ADDR_W-1:0]     i_buffer_address = '0;
    logic [LEN_W-1:0]      i_buffer_length  = '0;
    logic                  i_out_ready      = 1'b0;
    logic                  o_cfg_ready;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [SLOT_W-1:0]     o_slot_index;
    logic [31:0]           o_transaction_word;
    logic [SLEN_W-1:0]     o_slot_length;
    logic                  o_page_write;
    logic [PIDX_W-1:0]     o_page_index;
    logic [ADDR_W-1:0]     o_page_word;
    logic                  o_page_overflow;
    logic                  o_last;

    slot_scoreboard sb = new();
    bit             idle_on = 1'b1;
    int             cycle_count = 0;
    int             settings = 0;

    iso_descriptor_transaction_fill_core i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_buffer_address   (i_buffer_address),
        .i_buffer_length    (i_buffer_length),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_slot_index       (o_slot_index),
        .o_transaction_word (o_transaction_word),
        .o_slot_length      (o_slot_length),
        .o_page_write       (o_page_write),
        .o_page_index       (o_page_index),
        .o_page_word        (o_page_word),
        .o_page_overflow    (o_page_overflow),
        .o_last             (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[iso_descriptor_transaction_fill_core] ERROR");
            $finish;
        end
    end

    // result side: check accepted slots, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result('{slot: o_slot_index, word: o_transaction_word,
                              len: o_slot_length, pw: o_page_write, pidx: o_page_index,
                              pword: o_page_word, ovf: o_page_overflow, is_last: o_last});
        end
        i_out_ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic send_request(input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_buffer_address <= addr;
        i_buffer_length  <= len;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_request(addr, len);
    endtask

    task automatic wait_drained(input int settle);
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] mps, input logic [CFG_DATA_W-1:0] ppm,
                             input logic [CFG_DATA_W-1:0] low0, input logic [CFG_DATA_W-1:0] low1,
                             input logic [CFG_DATA_W-1:0] low2);
        wait_drained(SETTLE);
        write_reg(CFG_MAX_PACKET, mps);
        write_reg(CFG_MULT, ppm);
        // unused index, must leave every register alone
        write_reg(3'($urandom_range(CFG_FIRST_UNUSED, 7)), 12'($urandom));
        write_reg(CFG_PAGE0_LOW, low0);
        write_reg(CFG_PAGE1_LOW, low1);
        write_reg(CFG_PAGE2_LOW, low2);
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    initial begin
        logic [ADDR_W-1:0]     addr;
        logic [LEN_W-1:0]      len;
        logic [CFG_DATA_W-1:0] mps_d;
        logic [CFG_DATA_W-1:0] ppm_d;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: cap of 1024
        send_request(32'h0000_0000, 15'd0);
        send_request(32'h0000_0000, 15'd1);
        send_request(32'h0000_0000, 15'd1024);
        send_request(32'h0000_0000, 15'd1025);
        send_request(32'h0000_0000, 15'd8192);
        send_request(32'h0000_0000, 15'd8193);
        send_request(32'hFFFF_FFFF, 15'd24576);
        send_request(32'h0000_0FFF, 15'd4097);
        send_request(32'hFFFF_F800, 15'h7FFF);
        send_request(32'hAAAA_AAAA, 15'h5555);
        send_request(32'h5555_5555, 15'h2AAA);

        // largest cap, all low bits set
        configure(12'd1024, 12'd3, 12'hFFF, 12'hFFF, 12'hFFF);
        send_request(32'h0000_0000, 15'd24576);
        send_request(32'h0000_0C00, 15'd24576);
        send_request(32'hFFFF_F000, 15'd24576);
        send_request(32'h0000_0FFF, 15'd3073);

        // zero packet size gives zero-length active slots
        configure(12'd0, 12'd3, 12'h000, 12'h800, 12'h001);
        send_request(32'h0000_1234, 15'd100);
        send_request(32'h0000_1234, 15'd0);

        // zero multiplier, packet size above its width
        configure(12'hFFF, 12'hFFC, 12'h5A5, 12'hA5A, 12'h000);
        send_request(32'h8000_0FF0, 15'd5000);

        // largest packet size
        configure(12'h7FF, 12'd1, 12'h123, 12'h456, 12'h789);
        send_request(32'h0000_0FFF, 15'd24576);
        send_request(32'h0000_0000, 15'd16376);
        send_request(32'hFFFF_FFFE, 15'd2049);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(5))
                0:       mps_d = 12'd0;
                1:       mps_d = $urandom_range(1) ? 12'h7FF : 12'hFFF;
                2:       mps_d = 12'($urandom_range(1, 8));
                3:       mps_d = 12'd1024;
                default: mps_d = 12'($urandom);
            endcase
            ppm_d = $urandom_range(7) == 0 ? 12'($urandom)
                                          : {10'($urandom), 2'($urandom_range(1, 3))};
            configure(mps_d, ppm_d, 12'($urandom), 12'($urandom), 12'($urandom));
            idle_on = (ph != 2);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                case ($urandom_range(9))
                    0:       len = '0;
                    1:       len = 15'($urandom);
                    2, 3:    len = 15'($urandom_range(64));
                    default: len = 15'($urandom_range(24576));
                endcase
                case ($urandom_range(3))
                    0:       addr = {20'($urandom), 12'hFFF - 12'($urandom_range(16))};
                    1:       addr = 32'hFFFF_FFFF - 32'($urandom_range(8192));
                    default: addr = $urandom;
                endcase
                send_request(addr, len);
                if (ph == 1 && i == PHASE_ITEMS / 2) wait_drained(0);
            end
        end
        idle_on = 1'b1;

        wait_drained(SETTLE);
        $display("%0d requests over %0d register settings, %0d slot results checked",
                 sb.requests, settings + 1, sb.checked);
        $display("%0d active slots, %0d page pointer writes, %0d mismatches",
                 sb.active_slots, sb.page_writes, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[iso_descriptor_transaction_fill_core] OK");
        end else begin
            $display("[iso_descriptor_transaction_fill_core] ERROR");
        end
        $finish;
    end

endmodule

// File: iso_descriptor_transaction_fill_core.f
hw/rtl/idtf_pkg.sv
hw/rtl/idtf_seq.sv
hw/rtl/idtf_pack.sv
hw/rtl/iso_descriptor_transaction_fill_core.sv
tb/tb.sv
